/* hdl/rational_arith_unit_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic unit
// Each macro expands to a labeled concurrent assertion in simulation only.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rau_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int REQ_W = 3;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_RCP = 3'd4;
    localparam logic [2:0] OP_SQR = 3'd5;
endpackage

/* hdl/rational_arith_unit_core.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Signed fraction add/sub/mul/div/reciprocal/square with GCD reduction.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata low bit up)
// s_axis   in   tuser=req_type; tdata=a_num,a_den,b_num,b_den
// m_axis   out  tdata=res_num,res_den,status,result_zero,operands_equal
//
// Steps: accept, the multiply states MUL1 and MUL2 on one shared multiplier, a combine
// state (the same multiplier forms ad*bd there for add/subtract). A shared
// restoring divider (1 quotient bit per cycle, 2W+1 bits) then runs k Euclidean
// remainder steps and the two reducing divisions (k up to about 46 for W=16).
// An error skips the divider and goes from the combine state to the output.
// Reset: synchronous active low, clears control and output valid.
// Stalls: input is ready only when idle; a waiting result holds the output
// register, the next item may run meanwhile and waits for it to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_arith_unit_core_assert.svh"
module rational_arith_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [4*OPERAND_WIDTH-1:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]                 s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [71:0]                m_axis_tdata   // res_num, res_den, status,
                                                      // result_zero, operands_equal, pad
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;            // raw magnitude width
    localparam int CW = $clog2(PW + 1);
    localparam int RES_NUM_W_L = rau_pkg::RES_NUM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DVN  = 3'd5;
    localparam logic [2:0] S_DVD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]    r_state;
    logic [2:0]    r_op;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic          r_ann, r_adn, r_bnn, r_bdn;
    logic          r_eq, r_err;
    logic [2*W-1:0] r_p0, r_p1;
    logic          r_p0n, r_p1n;
    logic [PW-1:0] r_nm, r_dm, r_gx, r_gy;
    logic          r_nneg;
    // divider
    logic [PW-1:0] r_rem, r_quo, r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_dbusy;
    logic [PW-1:0] r_nq;
    logic          r_ovld;
    logic [RES_NUM_W_L-1:0] r_onum;
    logic [rau_pkg::RES_DEN_W-1:0] r_oden;
    logic r_ost, r_oz, r_oeq;

    // sign/magnitude of inputs
    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [W-1:0] w_in [4];
    always_comb begin
        for (int k = 0; k < 4; k++) w_in[k] = s_axis_tdata[k*W +: W];
    end

    // shared multiplier operand select; the combine cycle forms ad*bd
    logic [W-1:0] w_ma, w_mb;
    always_comb begin
        w_ma = r_ad; w_mb = r_bd;
        if (r_state == S_MUL1) begin
            unique case (r_op)
                rau_pkg::OP_MUL: begin w_ma = r_an; w_mb = r_bn; end
                rau_pkg::OP_SQR: begin w_ma = r_an; w_mb = r_an; end
                default:         begin w_ma = r_an; w_mb = r_bd; end
            endcase
        end else if (r_state == S_MUL2) begin
            unique case (r_op)
                rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin w_ma = r_bn; w_mb = r_ad; end
                rau_pkg::OP_DIV: begin w_ma = r_ad; w_mb = r_bn; end
                rau_pkg::OP_SQR: begin w_ma = r_ad; w_mb = r_ad; end
                default:         begin w_ma = r_ad; w_mb = r_bd; end
            endcase
        end
    end
    logic [2*W-1:0] w_prod;
    assign w_prod = w_ma * w_mb;

    // restoring divide step
    logic [PW:0]   w_trial;
    logic [PW-1:0] w_shr;
    assign w_shr   = {r_rem[PW-2:0], r_quo[PW-1]};
    assign w_trial = {1'b0, w_shr} - {1'b0, r_dvs};

    logic [PW-1:0] w_nquo_bit;
    assign w_nquo_bit = {r_quo[PW-2:0], ~w_trial[PW]};

    logic [PW:0] w_sum;
    logic [PW-1:0] w_am, w_bm;
    logic w_as, w_bs;
    always_comb begin
        w_am = {1'b0, r_p0};
        w_bm = {1'b0, r_p1};
        w_as = r_p0n;
        w_bs = r_p1n ^ (r_op == rau_pkg::OP_SUB);
        w_sum = (w_as == w_bs) ? {1'b0, w_am} + {1'b0, w_bm}
              : ({1'b0, w_am} - {1'b0, w_bm});
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op  <= s_axis_tuser;
                    r_an  <= f_mag(w_in[0]); r_ann <= w_in[0][W-1];
                    r_ad  <= f_mag(w_in[1]); r_adn <= w_in[1][W-1];
                    r_bn  <= f_mag(w_in[2]); r_bnn <= w_in[2][W-1];
                    r_bd  <= f_mag(w_in[3]); r_bdn <= w_in[3][W-1];
                    r_eq  <= (w_in[0] == w_in[2]) && (w_in[1] == w_in[3]);
                    r_err <= (w_in[1] == '0) || (s_axis_tuser > rau_pkg::OP_SQR) ||
                             ((s_axis_tuser <= rau_pkg::OP_DIV) && (w_in[3] == '0)) ||
                             ((s_axis_tuser == rau_pkg::OP_DIV) && (w_in[2] == '0)) ||
                             ((s_axis_tuser == rau_pkg::OP_RCP) && (w_in[0] == '0));
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p0 <= w_prod;
                    r_p0n <= (r_op == rau_pkg::OP_MUL) ? r_ann ^ r_bnn
                           : (r_op == rau_pkg::OP_SQR) ? 1'b0 : r_ann ^ r_bdn;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p1 <= w_prod;
                    r_p1n <= (r_op == rau_pkg::OP_DIV) ? r_adn ^ r_bnn
                           : (r_op == rau_pkg::OP_SQR) ? 1'b0
                           : (r_op <= rau_pkg::OP_SUB) ? r_bnn ^ r_adn : r_adn ^ r_bdn;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    // numerator and denominator magnitudes
                    if (r_op <= rau_pkg::OP_SUB) begin
                        // signed sum of the cross products; ad*bd on the multiplier
                        r_nm <= w_sum[PW] ? (~w_sum[PW-1:0] + 1'b1) : w_sum[PW-1:0];
                        r_dm <= {1'b0, w_prod};
                        r_nneg <= (w_sum[PW] ? w_bs : w_as) ^ r_adn ^ r_bdn;
                    end else if (r_op == rau_pkg::OP_RCP) begin
                        r_nm <= {{(PW-W){1'b0}}, r_ad};
                        r_dm <= {{(PW-W){1'b0}}, r_an};
                        r_nneg <= r_adn ^ r_ann;
                    end else begin
                        r_nm <= {1'b0, r_p0};
                        r_dm <= {1'b0, r_p1};
                        r_nneg <= r_p0n ^ r_p1n;
                    end
                    r_state <= r_err ? S_OUT : S_GCD;
                    r_gx <= '0; r_gy <= '0;
                end
                S_GCD: begin
                    if (!r_dbusy) begin
                        if (r_gx == '0 && r_gy == '0) begin
                            r_gx <= r_nm; r_gy <= r_dm;
                        end else if (r_gy == '0) begin
                            // gcd in r_gx; divide numerator
                            r_rem <= '0; r_quo <= r_nm; r_dvs <= r_gx;
                            r_cnt <= '0; r_dbusy <= 1'b1; r_state <= S_DVN;
                        end else begin
                            r_rem <= '0; r_quo <= r_gx; r_dvs <= r_gy;
                            r_cnt <= '0; r_dbusy <= 1'b1;
                        end
                    end else begin
                        r_rem <= w_trial[PW] ? w_shr : w_trial[PW-1:0];
                        r_quo <= w_nquo_bit;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(PW-1)) begin
                            r_dbusy <= 1'b0;
                            r_gx <= r_gy;
                            r_gy <= w_trial[PW] ? w_shr : w_trial[PW-1:0];
                        end
                    end
                end
                S_DVN, S_DVD: begin
                    if (!r_dbusy) begin
                        r_rem <= '0; r_quo <= r_dm; r_dvs <= r_gx;
                        r_cnt <= '0; r_dbusy <= 1'b1;
                    end else begin
                        r_rem <= w_trial[PW] ? w_shr : w_trial[PW-1:0];
                        r_quo <= w_nquo_bit;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CW'(PW-1)) begin
                            r_dbusy <= 1'b0;
                            if (r_state == S_DVN) begin
                                r_nq <= w_nquo_bit;
                                r_state <= S_DVD;
                            end else begin
                                r_dm <= w_nquo_bit;
                                r_state <= S_OUT;
                            end
                        end
                    end
                end
                S_OUT: if (!r_ovld) begin
                    r_ovld <= 1'b1;
                    r_oeq <= r_eq;
                    if (r_err) begin
                        r_onum <= '0; r_oden <= '0; r_ost <= 1'b1; r_oz <= 1'b0;
                    end else begin
                        r_ost <= 1'b0;
                        r_oz <= (r_nq == '0);
                        // negate at the full field width
                        r_onum <= (r_nneg && r_nq != '0)
                                ? (~RES_NUM_W_L'(r_nq) + 1'b1) : RES_NUM_W_L'(r_nq);
                        r_oden <= rau_pkg::RES_DEN_W'(r_dm);
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {5'd0, r_oeq, r_oz, r_ost, r_oden, r_onum};

    `RAU_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_ovld && r_ost, r_oden == '0 && !r_oz)
    `RAU_ASSERT_IMP(a_ok_den, i_clk, i_rst_n, r_ovld && !r_ost, r_oden != '0)
endmodule
